[rtl/assert_macros.svh]
// Assertion macros shared by the RTL; clk and rst must be in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define JVI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jvi assertion failed");

// Consequent checked in the cycle after the antecedent.
`define JVI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jvi assertion failed");

`endif

[rtl/jvi_pkg.sv]
// Types and constants shared by the jog velocity integrator.
package jvi_pkg;

  localparam int NUM_AXES   = 3;
  localparam int AXIS_W     = $clog2(NUM_AXES);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int DIR_W      = 10;
  localparam int MUL_A_W    = 24;
  localparam int MUL_B_W    = 16;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Z   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INSTANT = 3'd7;

  localparam logic [CFG_DATA_W-1:0] ACCEL_RST = 15'd256;
  localparam logic [CFG_DATA_W-1:0] MAX_RST   = 15'd2560;
  localparam logic [CFG_DATA_W-1:0] MIN_RST   = 15'd0;

  // drive direction codes, 8 fraction bits
  localparam logic signed [DIR_W-1:0] DIR_ZERO  = 10'sd0;
  localparam logic signed [DIR_W-1:0] DIR_ONE   = 10'sd256;
  localparam logic signed [DIR_W-1:0] DIR_BOOST = 10'sd333;

  typedef struct packed {
    logic [15:0] tick_length;
    logic        key_pos_x;
    logic        key_neg_x;
    logic        key_pos_y;
    logic        key_neg_y;
    logic        key_pos_z;
    logic        key_neg_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] position_z;
    logic signed [15:0] velocity_x;
    logic signed [15:0] velocity_y;
    logic signed [15:0] velocity_z;
  } result_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0]               accel;
    logic [NUM_AXES-1:0][CFG_DATA_W-1:0] max_speed;
    logic [NUM_AXES-1:0][CFG_DATA_W-1:0] min_speed;
    logic                                instant_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir;
    logic signed [15:0]      spd;
  } dir_res_t;

endpackage

[rtl/jvi_cfg.sv]
// Configuration register file: acceleration, per-axis limits and mode.
module jvi_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [jvi_pkg::CFG_IDX_W-1:0]    index,
  input  logic [jvi_pkg::CFG_DATA_W-1:0]   data,
  output jvi_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel        <= jvi_pkg::ACCEL_RST;
      cfg.max_speed    <= {jvi_pkg::NUM_AXES{jvi_pkg::MAX_RST}};
      cfg.min_speed    <= {jvi_pkg::NUM_AXES{jvi_pkg::MIN_RST}};
      cfg.instant_mode <= 1'b0;
    end else if (we) begin
      case (index)
        jvi_pkg::REG_ACCEL:   cfg.accel        <= data;
        jvi_pkg::REG_MAX_X:   cfg.max_speed[0] <= data;
        jvi_pkg::REG_MAX_Y:   cfg.max_speed[1] <= data;
        jvi_pkg::REG_MAX_Z:   cfg.max_speed[2] <= data;
        jvi_pkg::REG_MIN_X:   cfg.min_speed[0] <= data;
        jvi_pkg::REG_MIN_Y:   cfg.min_speed[1] <= data;
        jvi_pkg::REG_MIN_Z:   cfg.min_speed[2] <= data;
        jvi_pkg::REG_INSTANT: cfg.instant_mode <= data[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/jvi_dir.sv]
// Drive direction from the jog keys, plus speed clamp and dead-zone snap.
module jvi_dir (
  input  logic                            instant,
  input  logic [jvi_pkg::CFG_DATA_W-1:0]  max_speed,
  input  logic [jvi_pkg::CFG_DATA_W-1:0]  min_speed,
  input  logic signed [15:0]              spd,
  input  logic                            key_pos,
  input  logic                            key_neg,
  output jvi_pkg::dir_res_t               res
);

  logic signed [16:0]                s;
  logic signed [16:0]                mxs;
  logic signed [16:0]                mns;
  logic signed [16:0]                cap;
  logic signed [jvi_pkg::DIR_W-1:0]  d_raw;
  logic signed [jvi_pkg::DIR_W-1:0]  d;

  always_comb begin
    s   = {spd[15], spd};
    mxs = {2'b00, max_speed};
    mns = {2'b00, min_speed};

    if (key_pos && !key_neg) begin
      if (s > mxs)       d_raw = jvi_pkg::DIR_ZERO;
      else if (s < mns)  d_raw = jvi_pkg::DIR_BOOST;
      else               d_raw = jvi_pkg::DIR_ONE;
    end else if (key_neg && !key_pos) begin
      if (s < -mxs)      d_raw = jvi_pkg::DIR_ZERO;
      else if (s > -mns) d_raw = -jvi_pkg::DIR_BOOST;
      else               d_raw = -jvi_pkg::DIR_ONE;
    end else if (s >= -mns && s <= mns) begin
      d_raw = jvi_pkg::DIR_ZERO;
    end else if (s > 17'sd0) begin
      d_raw = -jvi_pkg::DIR_ONE;   // coast back toward zero
    end else begin
      d_raw = jvi_pkg::DIR_ONE;
    end

    d   = d_raw;
    cap = s;
    // instant mode leaves the stored speed untouched
    if (!instant) begin
      if (cap < -mxs) begin
        cap = -mxs;
        if (d < jvi_pkg::DIR_ZERO) d = jvi_pkg::DIR_ZERO;
      end
      if (cap > mxs) begin
        cap = mxs;
        if (d > jvi_pkg::DIR_ZERO) d = jvi_pkg::DIR_ZERO;
      end
      if (cap >= -mns && cap <= mns &&
          ((cap > 17'sd0 && !(d > jvi_pkg::DIR_ZERO)) ||
           (cap < 17'sd0 && !(d < jvi_pkg::DIR_ZERO)))) begin
        d   = jvi_pkg::DIR_ZERO;
        cap = 17'sd0;
      end
    end

    res.dir = d;
    res.spd = cap[15:0];
  end

endmodule

[rtl/jvi_mul.sv]
// Shared unsigned multiplier with a registered product.
module jvi_mul (
  input  logic                          clk,
  input  logic                          en,
  input  logic [jvi_pkg::MUL_A_W-1:0]   a,
  input  logic [jvi_pkg::MUL_B_W-1:0]   b,
  output logic [jvi_pkg::MUL_P_W-1:0]   p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= jvi_pkg::MUL_P_W'(a) * jvi_pkg::MUL_P_W'(b);
    end
  end

endmodule

[rtl/three_axis_jog_velocity_integrator.sv]
// Three-axis jog velocity integrator, top level. One tick transaction updates the x, y and z
// axes in turn through a single shared 24x16 multiplier, so the block takes one tick at a
// time: in normal mode each axis steps through direction and accel*dir, *dt, speed update,
// speed*dt and position update; in instant mode only through direction and max_speed*dir, *dt
// and position update. The result is then loaded and the block returns to idle.
// The result sits in an output register, so a new tick is taken while it waits. Speeds
// are signed Q8.8 and saturate, positions are Q16.16 and wrap. Configuration is written
// while no tick is in flight.
`include "assert_macros.svh"

module three_axis_jog_velocity_integrator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  jvi_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output jvi_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jvi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jvi_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIR  = 7'b0000010,
    S_MULB = 7'b0000100,
    S_UPD  = 7'b0001000,
    S_MULC = 7'b0010000,
    S_POS  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  localparam logic [40:0] RND_SPD  = 41'h0000800000;  // half LSB for >>24
  localparam logic [40:0] RND_IPOS = 41'h0000008000;  // half LSB for >>16
  localparam logic [32:0] RND_NPOS = 33'h000000080;   // half LSB for >>8

  state_t                                state;
  logic [jvi_pkg::AXIS_W-1:0]            axis;
  jvi_pkg::item_t                        item_r;
  logic signed [jvi_pkg::DIR_W-1:0]      dir_r;
  logic signed [15:0]                    spd_w;
  logic signed [15:0]                    axis_speed [jvi_pkg::NUM_AXES];
  logic [31:0]                           axis_position [jvi_pkg::NUM_AXES];

  jvi_pkg::cfg_t                         cfg;
  jvi_pkg::dir_res_t                     dres;
  logic                                  key_pos;
  logic                                  key_neg;
  logic [jvi_pkg::DIR_W-1:0]             dir_abs;
  logic [16:0]                           spd_mag;

  logic                                  mul_en;
  logic [jvi_pkg::MUL_A_W-1:0]           mul_a;
  logic [jvi_pkg::MUL_B_W-1:0]           mul_b;
  logic [jvi_pkg::MUL_P_W-1:0]           mul_p;

  logic [40:0]                           sum_spd;
  logic [40:0]                           sum_ipos;
  logic [32:0]                           sum_npos;
  logic [16:0]                           r_spd;
  logic [24:0]                           r_ipos;
  logic [23:0]                           r_npos;
  logic signed [18:0]                    delta;
  logic signed [18:0]                    spd_sum;
  logic signed [15:0]                    spd_sat;
  logic [31:0]                           pos_step;
  logic [31:0]                           pos_new;

  jvi_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  always_comb begin
    case (axis)
      2'd0: begin
        key_pos = item_r.key_pos_x;
        key_neg = item_r.key_neg_x;
      end
      2'd1: begin
        key_pos = item_r.key_pos_y;
        key_neg = item_r.key_neg_y;
      end
      default: begin
        key_pos = item_r.key_pos_z;
        key_neg = item_r.key_neg_z;
      end
    endcase
  end

  jvi_dir u_dir (
    .instant   (cfg.instant_mode),
    .max_speed (cfg.max_speed[axis]),
    .min_speed (cfg.min_speed[axis]),
    .spd       (axis_speed[axis]),
    .key_pos   (key_pos),
    .key_neg   (key_neg),
    .res       (dres)
  );

  assign dir_abs = dres.dir[jvi_pkg::DIR_W-1] ? 10'(-dres.dir) : 10'(dres.dir);
  assign spd_mag = spd_w[15] ? 17'(-{spd_w[15], spd_w}) : {1'b0, spd_w};

  // operand select for the shared multiplier
  always_comb begin
    case (state)
      S_DIR: begin
        mul_en = 1'b1;
        mul_a  = cfg.instant_mode ? {9'b0, cfg.max_speed[axis]} : {9'b0, cfg.accel};
        mul_b  = {7'b0, dir_abs[8:0]};
      end
      S_MULB: begin
        mul_en = 1'b1;
        mul_a  = mul_p[23:0];
        mul_b  = item_r.tick_length;
      end
      S_MULC: begin
        mul_en = 1'b1;
        mul_a  = {7'b0, spd_mag};
        mul_b  = item_r.tick_length;
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  jvi_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // round-half-away on magnitudes, then reapply sign
  always_comb begin
    sum_spd  = {1'b0, mul_p} + RND_SPD;
    sum_ipos = {1'b0, mul_p} + RND_IPOS;
    sum_npos = {1'b0, mul_p[31:0]} + RND_NPOS;
    r_spd    = sum_spd[40:24];
    r_ipos   = sum_ipos[40:16];
    r_npos   = sum_npos[31:8];

    delta   = dir_r[jvi_pkg::DIR_W-1] ? -$signed({2'b00, r_spd}) : $signed({2'b00, r_spd});
    spd_sum = {{3{spd_w[15]}}, spd_w} + delta;
    if (spd_sum > 19'sd32767)       spd_sat = 16'sh7fff;
    else if (spd_sum < -19'sd32768) spd_sat = 16'sh8000;
    else                            spd_sat = spd_sum[15:0];

    if (state == S_UPD) begin
      pos_step = dir_r[jvi_pkg::DIR_W-1] ? -{7'b0, r_ipos} : {7'b0, r_ipos};
    end else begin
      pos_step = spd_w[15] ? -{8'b0, r_npos} : {8'b0, r_npos};
    end
    pos_new = axis_position[axis] + pos_step;
  end

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = (state == S_IDLE);

  // control and axis state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      axis         <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < jvi_pkg::NUM_AXES; i++) begin
        axis_speed[i]    <= '0;
        axis_position[i] <= '0;
      end
    end else begin
      if (state == S_OUT && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            axis  <= '0;
            state <= S_DIR;
          end
        end
        S_DIR:  state <= S_MULB;
        S_MULB: state <= S_UPD;
        S_UPD: begin
          if (cfg.instant_mode) begin
            axis_position[axis] <= pos_new;
            if (axis == jvi_pkg::AXIS_LAST) begin
              state <= S_OUT;
            end else begin
              axis  <= axis + 1'b1;
              state <= S_DIR;
            end
          end else begin
            axis_speed[axis] <= spd_sat;
            state            <= S_MULC;
          end
        end
        S_MULC: state <= S_POS;
        S_POS: begin
          axis_position[axis] <= pos_new;
          if (axis == jvi_pkg::AXIS_LAST) begin
            state <= S_OUT;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_DIR;
          end
        end
        S_OUT: begin
          // hold until the previous result has gone
          if (!result_valid || !result_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) item_r <= item;
    if (state == S_DIR) begin
      dir_r <= dres.dir;
      spd_w <= dres.spd;
    end
    if (state == S_UPD && !cfg.instant_mode) spd_w <= spd_sat;
    if (state == S_OUT && (!result_valid || !result_stall)) begin
      result.position_x <= axis_position[0];
      result.position_y <= axis_position[1];
      result.position_z <= axis_position[2];
      result.velocity_x <= axis_speed[0];
      result.velocity_y <= axis_speed[1];
      result.velocity_z <= axis_speed[2];
    end
  end

  `JVI_ASSERT_NEXT(a_start_axis0, item_valid && !item_stall, state == S_DIR && axis == '0)
  `JVI_ASSERT_NEXT(a_out_holds, state == S_OUT && result_valid && result_stall, state == S_OUT)
  `JVI_ASSERT_NEXT(a_instant_keeps_speed, state == S_UPD && cfg.instant_mode, $stable(axis_speed[0]) && $stable(axis_speed[1]) && $stable(axis_speed[2]))

endmodule

[sim/three_axis_jog_velocity_integrator_test.sv]
// Self-checking testbench for the jog velocity integrator: directed ticks, then random phases.
module three_axis_jog_velocity_integrator_test;

  typedef struct {
    bit                             is_reg;
    logic [jvi_pkg::CFG_IDX_W-1:0]  idx;
    logic [jvi_pkg::CFG_DATA_W-1:0] data;
    jvi_pkg::item_t                 tick;
    bit                             has_known;
    jvi_pkg::result_t               known;
  } script_row_t;

  bit clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  jvi_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  jvi_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [jvi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [jvi_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of registers and axis state
  int accel_q = 256;
  int speed_limit[3] = '{2560, 2560, 2560};
  int dead_zone[3] = '{0, 0, 0};
  bit instant_q = 1'b0;
  int axis_vel[3] = '{0, 0, 0};
  logic [31:0] axis_pos[3] = '{0, 0, 0};

  jvi_pkg::result_t pending_motion[$];
  script_row_t jog_script[$];
  int mismatches = 0;
  bit steady = 1'b0;
  bit hold_pending = 1'b0;
  int hold_left = 0;

  three_axis_jog_velocity_integrator dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #12000000;
    $display("FAIL three_axis_jog_velocity_integrator");
    $finish;
  end

  function automatic longint round_shift(longint v, int s);
    longint m;
    longint r;
    m = (v < 0) ? -v : v;
    r = (m + (longint'(1) << (s - 1))) >> s;
    return (v < 0) ? -r : r;
  endfunction

  function automatic int steer(int lim, int dz, int spd, bit p, bit n);
    if (p && !n) begin
      if (spd > lim) return 0;
      if (spd < dz) return int'(jvi_pkg::DIR_BOOST);
      return int'(jvi_pkg::DIR_ONE);
    end
    if (n && !p) begin
      if (spd < -lim) return 0;
      if (spd > -dz) return -int'(jvi_pkg::DIR_BOOST);
      return -int'(jvi_pkg::DIR_ONE);
    end
    if (spd >= -dz && spd <= dz) return 0;
    return (spd > 0) ? -int'(jvi_pkg::DIR_ONE) : int'(jvi_pkg::DIR_ONE);
  endfunction

  // one tick over all three axes; updates the predictor state
  function automatic jvi_pkg::result_t advance_axes(jvi_pkg::item_t t);
    jvi_pkg::result_t r;
    logic [5:0] keys;
    longint dt;
    longint ns;
    longint dpos;
    int lim;
    int dz;
    int spd;
    int dir;
    keys = {t.key_pos_x, t.key_neg_x, t.key_pos_y, t.key_neg_y, t.key_pos_z, t.key_neg_z};
    dt = longint'(t.tick_length);
    for (int a = 0; a < 3; a++) begin
      lim = speed_limit[a];
      dz = dead_zone[a];
      spd = axis_vel[a];
      dir = steer(lim, dz, spd, keys[5 - 2 * a], keys[4 - 2 * a]);
      if (instant_q) begin
        dpos = round_shift(longint'(dir) * lim * dt, 16);
      end else begin
        if (spd < -lim) begin
          spd = -lim;
          if (dir < 0) dir = 0;
        end
        if (spd > lim) begin
          spd = lim;
          if (dir > 0) dir = 0;
        end
        // dead zone snap unless pushed away from zero
        if (spd >= -dz && spd <= dz) begin
          if ((spd > 0 && !(dir > 0)) || (spd < 0 && !(dir < 0))) begin
            dir = 0;
            spd = 0;
          end
        end
        ns = longint'(spd) + round_shift(longint'(accel_q) * dir * dt, 24);
        if (ns > 32767) ns = 32767;
        if (ns < -32768) ns = -32768;
        axis_vel[a] = int'(ns);
        dpos = round_shift(longint'(axis_vel[a]) * dt, 8);
      end
      axis_pos[a] = axis_pos[a] + dpos[31:0];
    end
    r.position_x = axis_pos[0];
    r.position_y = axis_pos[1];
    r.position_z = axis_pos[2];
    r.velocity_x = axis_vel[0][15:0];
    r.velocity_y = axis_vel[1][15:0];
    r.velocity_z = axis_vel[2][15:0];
    return r;
  endfunction

  function automatic void add_tick(logic [15:0] dt, logic [5:0] keys, bit known_flag = 1'b0,
                                   jvi_pkg::result_t known_val = '0);
    script_row_t row;
    row.is_reg = 1'b0;
    row.idx = '0;
    row.data = '0;
    row.tick = jvi_pkg::item_t'({dt, keys});
    row.has_known = known_flag;
    row.known = known_val;
    jog_script.push_back(row);
  endfunction

  function automatic void add_reg(logic [jvi_pkg::CFG_IDX_W-1:0] idx,
                                  logic [jvi_pkg::CFG_DATA_W-1:0] data);
    script_row_t row;
    row.is_reg = 1'b1;
    row.idx = idx;
    row.data = data;
    row.tick = '0;
    row.has_known = 1'b0;
    row.known = '0;
    jog_script.push_back(row);
  endfunction

  function automatic void compare_field(string label, longint want, longint got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, got %0d", $time, label, want, got);
      mismatches++;
    end
  endfunction

  // leaves cfg_valid high; caller lowers it after the last write
  task automatic write_register(logic [jvi_pkg::CFG_IDX_W-1:0] idx,
                                logic [jvi_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      jvi_pkg::REG_ACCEL:   accel_q = int'(data);
      jvi_pkg::REG_MAX_X:   speed_limit[0] = int'(data);
      jvi_pkg::REG_MAX_Y:   speed_limit[1] = int'(data);
      jvi_pkg::REG_MAX_Z:   speed_limit[2] = int'(data);
      jvi_pkg::REG_MIN_X:   dead_zone[0] = int'(data);
      jvi_pkg::REG_MIN_Y:   dead_zone[1] = int'(data);
      jvi_pkg::REG_MIN_Z:   dead_zone[2] = int'(data);
      jvi_pkg::REG_INSTANT: instant_q = data[0];
      default: ;
    endcase
  endtask

  // leaves item_valid high so back-to-back ticks need no extra edge
  task automatic send_tick(jvi_pkg::item_t t, bit known_flag, jvi_pkg::result_t known_val);
    jvi_pkg::result_t predicted;
    if (!steady && $urandom_range(99) < 7) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= t;
    do @(posedge clk); while (item_stall);
    predicted = advance_axes(t);
    pending_motion.push_back(known_flag ? known_val : predicted);
  endtask

  task automatic settle();
    while (pending_motion.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin : take_result
    jvi_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_motion.size() == 0) begin
        $display("%0t unexpected transaction: got %h", $time, result);
        mismatches++;
      end else begin
        want = pending_motion.pop_front();
        compare_field("position_x", longint'(want.position_x), longint'(result.position_x));
        compare_field("position_y", longint'(want.position_y), longint'(result.position_y));
        compare_field("position_z", longint'(want.position_z), longint'(result.position_z));
        compare_field("velocity_x", longint'(want.velocity_x), longint'(result.velocity_x));
        compare_field("velocity_y", longint'(want.velocity_y), longint'(result.velocity_y));
        compare_field("velocity_z", longint'(want.velocity_z), longint'(result.velocity_z));
      end
    end
    if (hold_pending) begin
      hold_left = 300;
      hold_pending = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !steady && ($urandom_range(99) < 7);
    end
  end

  initial begin
    jvi_pkg::result_t zero_res;
    jvi_pkg::result_t first_push;
    logic [5:0] keys;
    logic [15:0] dt;
    logic [1:0] axis_mode[3];
    logic [jvi_pkg::CFG_DATA_W-1:0] acc_v;
    logic [jvi_pkg::CFG_DATA_W-1:0] lim_v[3];
    logic [jvi_pkg::CFG_DATA_W-1:0] dz_v[3];
    bit inst_v;
    int sel;

    zero_res = '0;
    first_push = '0;
    first_push.position_x = 32'sd65535;
    first_push.velocity_x = 16'sd256;
    axis_mode = '{2'b00, 2'b00, 2'b00};

    add_tick(16'd0, 6'b000000, 1'b1, zero_res);
    add_tick(16'hffff, 6'b100000, 1'b1, first_push);
    add_tick(16'hffff, 6'b100110);
    add_tick(16'hffff, 6'b111111);          // both buttons on every axis: coast
    add_tick(16'd0, 6'b010101);
    add_tick(16'd1, 6'b101010);
    add_tick(16'h8000, 6'b111000);
    add_reg(jvi_pkg::REG_MIN_X, 15'd1000);
    add_tick(16'd20000, 6'b000000);         // x speed inside dead zone snaps
    add_tick(16'hffff, 6'b010000);
    add_reg(jvi_pkg::REG_MAX_X, 15'd100);
    add_tick(16'hffff, 6'b010000);          // speed beyond the new limit is clamped
    add_tick(16'hffff, 6'b100000);
    add_reg(jvi_pkg::REG_ACCEL, 15'h7fff);
    add_reg(jvi_pkg::REG_MAX_Y, 15'h7fff);
    add_tick(16'hffff, 6'b001000);
    add_tick(16'hffff, 6'b001000);
    add_tick(16'hffff, 6'b001000);          // y speed saturates
    add_reg(jvi_pkg::REG_INSTANT, 15'd1);
    add_tick(16'hffff, 6'b100110);
    add_tick(16'd12345, 6'b110000);
    add_reg(jvi_pkg::REG_INSTANT, 15'd0);
    add_reg(jvi_pkg::REG_ACCEL, 15'd0);
    add_tick(16'hffff, 6'b000001);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (jog_script[i]) begin
      if (jog_script[i].is_reg) begin
        item_valid <= 1'b0;
        settle();
        write_register(jog_script[i].idx, jog_script[i].data);
        cfg_valid <= 1'b0;
      end else begin
        send_tick(jog_script[i].tick, jog_script[i].has_known, jog_script[i].known);
      end
    end

    for (int p = 0; p < 10; p++) begin
      item_valid <= 1'b0;
      settle();
      acc_v = 15'($urandom_range(32767));
      inst_v = 1'b0;
      foreach (lim_v[a]) begin
        lim_v[a] = 15'($urandom_range(32767));
        dz_v[a] = 15'($urandom_range(32767));
      end
      case (p)
        0: foreach (lim_v[a]) begin
          lim_v[a] = 15'($urandom_range(4096));
          dz_v[a] = 15'($urandom_range(512));
        end
        1: begin
          acc_v = 15'h7fff;
          foreach (lim_v[a]) begin
            lim_v[a] = 15'h7fff;
            dz_v[a] = '0;
          end
        end
        2: begin
          acc_v = '0;
          foreach (lim_v[a]) begin
            lim_v[a] = '0;
            dz_v[a] = '0;
          end
        end
        3: foreach (lim_v[a]) begin
          // minimum often above maximum
          lim_v[a] = 15'($urandom_range(2000));
          dz_v[a] = 15'($urandom_range(32767, 1000));
        end
        4: begin
          inst_v = 1'b1;
          foreach (dz_v[a]) dz_v[a] = 15'($urandom_range(2048));
        end
        5, 9: begin
          inst_v = (p == 5);
          acc_v = 15'h7fff;
          foreach (lim_v[a]) begin
            lim_v[a] = 15'h7fff;
            dz_v[a] = 15'h7fff;
          end
        end
        6: begin
          acc_v = 15'($urandom_range(2048, 1));
          foreach (lim_v[a]) begin
            lim_v[a] = 15'($urandom_range(8192, 256));
            dz_v[a] = 15'($urandom_range(256));
          end
        end
        7: begin
          inst_v = 1'b1;
          foreach (lim_v[a]) lim_v[a] = '0;
        end
        default: ;
      endcase
      write_register(jvi_pkg::REG_ACCEL, acc_v);
      write_register(jvi_pkg::REG_MAX_X, lim_v[0]);
      write_register(jvi_pkg::REG_MAX_Y, lim_v[1]);
      write_register(jvi_pkg::REG_MAX_Z, lim_v[2]);
      write_register(jvi_pkg::REG_MIN_X, dz_v[0]);
      write_register(jvi_pkg::REG_MIN_Y, dz_v[1]);
      write_register(jvi_pkg::REG_MIN_Z, dz_v[2]);
      // upper bits are don't-care for the mode register
      write_register(jvi_pkg::REG_INSTANT, {14'($urandom), inst_v});
      cfg_valid <= 1'b0;

      for (int k = 0; k < 200; k++) begin
        steady = (p == 6 && k < 150);
        if (p == 0 && k == 100) hold_pending = 1'b1;
        sel = $urandom_range(99);
        if (sel < 5) dt = 16'd0;
        else if (sel < 10) dt = 16'hffff;
        else if (sel < 40) dt = 16'($urandom_range(4095));
        else dt = 16'($urandom_range(65535));
        if ($urandom_range(99) < 10) begin
          keys = 6'($urandom_range(63));
        end else begin
          // buttons held over runs of ticks so speeds build up
          for (int a = 0; a < 3; a++) begin
            if ($urandom_range(99) < 15) begin
              sel = $urandom_range(9);
              if (sel < 2) axis_mode[a] = 2'b00;
              else if (sel < 5) axis_mode[a] = 2'b10;
              else if (sel < 8) axis_mode[a] = 2'b01;
              else axis_mode[a] = 2'b11;
            end
            keys[5 - 2 * a -: 2] = axis_mode[a];
          end
        end
        send_tick(jvi_pkg::item_t'({dt, keys}), 1'b0, zero_res);
      end
    end

    steady = 1'b0;
    item_valid <= 1'b0;
    settle();
    if (mismatches == 0) begin
      $display("PASS three_axis_jog_velocity_integrator");
    end else begin
      $display("FAIL three_axis_jog_velocity_integrator");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/jvi_pkg.sv
rtl/jvi_cfg.sv
rtl/jvi_dir.sv
rtl/jvi_mul.sv
rtl/three_axis_jog_velocity_integrator.sv
sim/three_axis_jog_velocity_integrator_test.sv
